>>> design/ctg_pkg.sv
// Shared constants, register codes and stage bundles of the cubic trajectory generator.
// No dependencies; every other file of the block imports this package.
package ctg_pkg;

   // Axes on the ports, and axes that take part in the move.
   localparam int PORT_AXES = 3;
   localparam int AXES      = 3;

   localparam int FRAC = 28;

   // Long division: 64-bit dividend, 40-bit divisor, two quotient bits per stage.
   localparam int DIVIDEND_W = 64;
   localparam int DIVISOR_W  = 40;
   localparam int DIV_STAGES = 32;
   localparam int DIV_STEPS  = DIVIDEND_W / DIV_STAGES;

   // Pipeline bookkeeping, in register stages.
   localparam int FRONT_LAT  = 4;
   localparam int POLY_LAT   = 3;
   localparam int AXIS_LAT   = DIV_STAGES + 4;
   localparam int SIDE_DELAY = DIV_STAGES + POLY_LAT;
   localparam int TAIL_DELAY = DIV_STAGES + 2;
   localparam int HOLD_DELAY = AXIS_LAT - 1;
   localparam int PIPE_LAT   = FRONT_LAT + SIDE_DELAY + AXIS_LAT;

   localparam logic [28:0] ONE_Q   = 29'h1000_0000;
   localparam logic [31:0] C3_BASE = 32'd1610612736;

   // Quotients at or above these saturate after scaling to seconds.
   localparam logic [63:0] VEL_LIMIT  = 64'd576460752303424;
   localparam logic [63:0] ACC_LIMIT  = 64'd576460752304;
   localparam logic [9:0]  MS_PER_S   = 10'd1000;
   localparam logic [19:0] MS2_PER_S2 = 20'd1000000;

   localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_MIN = 32'h8000_0000;

   typedef enum logic [2:0] {
      REG_TARGET_X       = 3'd0,
      REG_TARGET_Y       = 3'd1,
      REG_TARGET_Z       = 3'd2,
      REG_MOVE_DURATION  = 3'd3,
      REG_STOP_TOLERANCE = 3'd4
   } reg_index_type;

   localparam logic [31:0] TARGET_X_RESET       = 32'd0;
   localparam logic [31:0] TARGET_Y_RESET       = 32'd0;
   localparam logic [30:0] TARGET_Z_RESET       = 31'd65536;
   localparam logic [19:0] MOVE_DURATION_RESET  = 20'd5000;
   localparam logic [30:0] STOP_TOLERANCE_RESET = 31'd655;

   typedef struct packed {
      logic [PORT_AXES-1:0][31:0] cur;
      logic [PORT_AXES-1:0][31:0] start;
      logic [PORT_AXES-1:0][31:0] dmag;
      logic [PORT_AXES-1:0]       dneg;
      logic                       hold;
   } side_type;

   typedef struct packed {
      logic [PORT_AXES-1:0][31:0] cur;
      logic                       hold;
   } override_type;

   typedef struct packed {
      logic [29:0] c1;
      logic [28:0] c2;
      logic [30:0] c3m;
      logic        c3neg;
   } coef_type;

   typedef struct packed {
      logic [DIVISOR_W-1:0]  rem;
      logic [DIVIDEND_W-1:0] work;
   } div_state_type;

endpackage

>>> design/cubic_trajectory_generator.sv
// Top level of the cubic trajectory generator: register file, pipeline valid bits, delays.
// Depends on ctg_pkg and instantiates ctg_front, ctg_divider, ctg_poly and ctg_axis.
//
// Usage. Each request beat carries the current hand position on three axes, the
// time since the move began in milliseconds and a new-move flag. Each request
// produces exactly one response beat with the reference position, velocity and
// acceleration per axis and a holding flag, in request order.
// The block is a fixed pipeline of 75 register stages, and one request beat can
// be taken in every cycle while the response is not stalled. Most of the depth
// comes from the two 32-stage long dividers (t/T ahead of the polynomial, then
// the velocity and acceleration divisions).
// When the response is not taken, the whole pipeline freezes with it and
// req_ready falls in the same cycle; no beat is lost or repeated.
// Reset clears all valid bits, loads the register defaults and arms the start
// latch, so the first request after reset becomes the start point of the move.
// Registers sit behind an APB-style port at byte addresses 4*i; write them only
// while no beat is in flight.
module cubic_trajectory_generator (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [19:0]        req_elapsed_ms,
   input  logic               req_new_move,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_ref_pos_x,
   output logic signed [31:0] rsp_ref_pos_y,
   output logic signed [31:0] rsp_ref_pos_z,
   output logic signed [31:0] rsp_ref_vel_x,
   output logic signed [31:0] rsp_ref_vel_y,
   output logic signed [31:0] rsp_ref_vel_z,
   output logic signed [31:0] rsp_ref_acc_x,
   output logic signed [31:0] rsp_ref_acc_y,
   output logic signed [31:0] rsp_ref_acc_z,
   output logic               rsp_holding,

   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import ctg_pkg::*;

   // Register file.
   logic [31:0] target_x_ff, target_y_ff;
   logic [30:0] target_z_ff;
   logic [19:0] move_duration_ff;
   logic [30:0] stop_tolerance_ff;
   logic [39:0] dur_sq_ff;
   logic        csr_write;
   reg_index_type csr_index;

   // Pipeline control. Every stage moves when the last stage is empty or taken.
   logic                advance;
   logic                accept;
   logic [PIPE_LAT-1:0] valid_ff;

   side_type     side_front;
   logic [19:0]  elapsed_front;
   side_type     side_line_ff [SIDE_DELAY];
   override_type hold_line_ff [HOLD_DELAY];
   override_type hold_line_in;
   logic         holding_ff;

   logic [DIVIDEND_W-1:0]       s_quot;
   coef_type                    coef;
   logic [PORT_AXES-1:0][32:0]  target_ext;
   logic [PORT_AXES-1:0][31:0]  pos_out, vel_out, acc_out;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_index = reg_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         target_x_ff       <= TARGET_X_RESET;
         target_y_ff       <= TARGET_Y_RESET;
         target_z_ff       <= TARGET_Z_RESET;
         move_duration_ff  <= MOVE_DURATION_RESET;
         stop_tolerance_ff <= STOP_TOLERANCE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_TARGET_X:       target_x_ff       <= pwdata;
            REG_TARGET_Y:       target_y_ff       <= pwdata;
            REG_TARGET_Z:       target_z_ff       <= pwdata[30:0];
            REG_MOVE_DURATION:  move_duration_ff  <= pwdata[19:0];
            REG_STOP_TOLERANCE: stop_tolerance_ff <= pwdata[30:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_TARGET_X:       prdata = target_x_ff;
         REG_TARGET_Y:       prdata = target_y_ff;
         REG_TARGET_Z:       prdata = {1'b0, target_z_ff};
         REG_MOVE_DURATION:  prdata = {12'b0, move_duration_ff};
         REG_STOP_TOLERANCE: prdata = {1'b0, stop_tolerance_ff};
         default:            prdata = '0;
      endcase
   end

   // The square of the duration divides the acceleration; it follows the
   // register in the next cycle, well inside the idle time after a write.
   always_ff @(posedge clock) begin
      dur_sq_ff <= 40'(move_duration_ff) * 40'(move_duration_ff);
   end

   assign target_ext[0] = {target_x_ff[31], target_x_ff};
   assign target_ext[1] = {target_y_ff[31], target_y_ff};
   assign target_ext[2] = {2'b00, target_z_ff};

   assign advance   = ~valid_ff[PIPE_LAT-1] | rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid & advance;
   assign rsp_valid = valid_ff[PIPE_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[PIPE_LAT-2:0], req_valid};
      end
   end

   ctg_front front (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .accept       (accept),
      .cur_in       ({req_pos_z, req_pos_y, req_pos_x}),
      .elapsed_in   (req_elapsed_ms),
      .new_move_in  (req_new_move),
      .target_in    (target_ext),
      .duration_in  (move_duration_ff),
      .tolerance_in (stop_tolerance_ff),
      .side_out     (side_front),
      .elapsed_out  (elapsed_front)
   );

   // s = t * 2^28 / T; only the low 28 quotient bits matter while moving.
   ctg_divider s_div (
      .clock    (clock),
      .advance  (advance),
      .dividend ({16'b0, elapsed_front, 28'b0}),
      .divisor  ({20'b0, move_duration_ff}),
      .quotient (s_quot)
   );

   ctg_poly poly (
      .clock    (clock),
      .advance  (advance),
      .s_in     (s_quot[27:0]),
      .coef_out (coef)
   );

   // Side data waits beside the s divider and the polynomial stages; then the
   // current position and the hold flag wait beside the axis pipelines.
   assign hold_line_in.cur  = side_line_ff[SIDE_DELAY-1].cur;
   assign hold_line_in.hold = side_line_ff[SIDE_DELAY-1].hold;

   always_ff @(posedge clock) begin
      if (advance) begin
         side_line_ff[0] <= side_front;
         for (int k = 1; k < SIDE_DELAY; k++) begin
            side_line_ff[k] <= side_line_ff[k-1];
         end
         hold_line_ff[0] <= hold_line_in;
         for (int k = 1; k < HOLD_DELAY; k++) begin
            hold_line_ff[k] <= hold_line_ff[k-1];
         end
         holding_ff <= hold_line_ff[HOLD_DELAY-1].hold;
      end
   end

   for (genvar ax = 0; ax < PORT_AXES; ax++) begin : g_axis
      ctg_axis axis (
         .clock       (clock),
         .advance     (advance),
         .dmag_in     (side_line_ff[SIDE_DELAY-1].dmag[ax]),
         .dneg_in     (side_line_ff[SIDE_DELAY-1].dneg[ax]),
         .start_in    (side_line_ff[SIDE_DELAY-1].start[ax]),
         .coef_in     (coef),
         .duration_in (move_duration_ff),
         .dur_sq_in   (dur_sq_ff),
         .cur_in      (hold_line_ff[HOLD_DELAY-1].cur[ax]),
         .pass_in     (hold_line_ff[HOLD_DELAY-1].hold || (ax >= AXES)),
         .pos_out     (pos_out[ax]),
         .vel_out     (vel_out[ax]),
         .acc_out     (acc_out[ax])
      );
   end

   assign rsp_ref_pos_x = pos_out[0];
   assign rsp_ref_pos_y = pos_out[1];
   assign rsp_ref_pos_z = pos_out[2];
   assign rsp_ref_vel_x = vel_out[0];
   assign rsp_ref_vel_y = vel_out[1];
   assign rsp_ref_vel_z = vel_out[2];
   assign rsp_ref_acc_x = acc_out[0];
   assign rsp_ref_acc_y = acc_out[1];
   assign rsp_ref_acc_z = acc_out[2];
   assign rsp_holding   = holding_ff;

endmodule

>>> design/ctg_divider.sv
// Pipelined restoring divider, two quotient bits per stage, with a common advance.
// Depends on ctg_pkg for widths and stage count.
module ctg_divider (
   input  logic                             clock,
   input  logic                             advance,
   input  logic [ctg_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [ctg_pkg::DIVISOR_W-1:0]    divisor,
   output logic [ctg_pkg::DIVIDEND_W-1:0]   quotient
);
   import ctg_pkg::*;

   div_state_type stage_ff [DIV_STAGES];
   div_state_type stage_in [DIV_STAGES];

   // The remainder stays below the divisor, so one subtraction per bit suffices.
   function automatic div_state_type div_stage(input div_state_type s,
                                               input logic [DIVISOR_W-1:0] d);
      div_state_type r;
      logic [DIVISOR_W:0] trial;
      r = s;
      for (int b = 0; b < DIV_STEPS; b++) begin
         trial  = {r.rem, r.work[DIVIDEND_W-1]};
         r.work = {r.work[DIVIDEND_W-2:0], 1'b0};
         if (trial >= {1'b0, d}) begin
            trial     = trial - {1'b0, d};
            r.work[0] = 1'b1;
         end
         r.rem = trial[DIVISOR_W-1:0];
      end
      return r;
   endfunction

   always_comb begin
      stage_in[0] = div_stage('{rem: '0, work: dividend}, divisor);
      for (int st = 1; st < DIV_STAGES; st++) begin
         stage_in[st] = div_stage(stage_ff[st-1], divisor);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign quotient = stage_ff[DIV_STAGES-1].work;

endmodule

>>> design/ctg_front.sv
// Input stages: start-point latch, start-to-target distances and the hold decision.
// Depends on ctg_pkg for the side bundle and axis counts.
module ctg_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic                                  accept,
   input  logic [ctg_pkg::PORT_AXES-1:0][31:0]   cur_in,
   input  logic [19:0]                           elapsed_in,
   input  logic                                  new_move_in,
   input  logic [ctg_pkg::PORT_AXES-1:0][32:0]   target_in,
   input  logic [19:0]                           duration_in,
   input  logic [30:0]                           tolerance_in,
   output ctg_pkg::side_type                     side_out,
   output logic [19:0]                           elapsed_out
);
   import ctg_pkg::*;

   logic [PORT_AXES-1:0][31:0] start_ff;
   logic                       latch_pending_ff;
   logic                       latch;
   logic [PORT_AXES-1:0][31:0] start_in;
   logic [61:0]                tol_sq_ff;

   logic [PORT_AXES-1:0][31:0] cur1_ff, start1_ff;
   logic [19:0]                t1_ff;

   logic [PORT_AXES-1:0][31:0] cur2_ff, start2_ff, dmag2_ff, dmag2_in;
   logic [PORT_AXES-1:0][32:0] mag2_ff, mag2_in;
   logic [PORT_AXES-1:0]       dneg2_ff, dneg2_in;
   logic [19:0]                t2_ff;
   logic                       tge2_ff;

   logic [PORT_AXES-1:0][31:0] cur3_ff, start3_ff, dmag3_ff;
   logic [PORT_AXES-1:0][61:0] sq3_ff, sq3_in;
   logic [PORT_AXES-1:0]       near3_ff, near3_in, dneg3_ff;
   logic [19:0]                t3_ff;
   logic                       tge3_ff;

   side_type                   side_ff, side_in;
   logic [19:0]                t4_ff;

   logic signed [32:0]         diff_v, dist_v;
   logic [63:0]                sum_v;
   logic                       near_all_v;

   assign latch    = latch_pending_ff | new_move_in;
   assign start_in = latch ? cur_in : start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff         <= '0;
         latch_pending_ff <= 1'b1;
      end else if (accept && latch) begin
         start_ff         <= cur_in;
         latch_pending_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      tol_sq_ff <= 62'(tolerance_in) * 62'(tolerance_in);
   end

   always_comb begin
      diff_v = '0;
      dist_v = '0;
      for (int i = 0; i < PORT_AXES; i++) begin
         diff_v      = $signed({cur1_ff[i][31], cur1_ff[i]}) - $signed(target_in[i]);
         mag2_in[i]  = diff_v[32] ? 33'(-diff_v) : 33'(diff_v);
         dist_v      = $signed(target_in[i]) - $signed({start1_ff[i][31], start1_ff[i]});
         dmag2_in[i] = dist_v[32] ? 32'(-dist_v) : 32'(dist_v);
         dneg2_in[i] = dist_v[32];
      end
   end

   always_comb begin
      for (int i = 0; i < PORT_AXES; i++) begin
         sq3_in[i]   = 62'(mag2_ff[i][30:0]) * 62'(mag2_ff[i][30:0]);
         near3_in[i] = mag2_ff[i] < {2'b00, tolerance_in};
      end
   end

   always_comb begin
      sum_v      = '0;
      near_all_v = 1'b1;
      for (int i = 0; i < PORT_AXES; i++) begin
         if (i < AXES) begin
            sum_v      = sum_v + 64'(sq3_ff[i]);
            near_all_v = near_all_v & near3_ff[i];
         end
      end
      side_in.cur   = cur3_ff;
      side_in.start = start3_ff;
      side_in.dmag  = dmag3_ff;
      side_in.dneg  = dneg3_ff;
      side_in.hold  = tge3_ff | ((tolerance_in != '0) & near_all_v &
                                 (sum_v < {2'b00, tol_sq_ff}));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cur1_ff   <= cur_in;
         start1_ff <= start_in;
         t1_ff     <= elapsed_in;

         cur2_ff   <= cur1_ff;
         start2_ff <= start1_ff;
         t2_ff     <= t1_ff;
         mag2_ff   <= mag2_in;
         dmag2_ff  <= dmag2_in;
         dneg2_ff  <= dneg2_in;
         tge2_ff   <= t1_ff >= duration_in;

         cur3_ff   <= cur2_ff;
         start3_ff <= start2_ff;
         dmag3_ff  <= dmag2_ff;
         dneg3_ff  <= dneg2_ff;
         t3_ff     <= t2_ff;
         tge3_ff   <= tge2_ff;
         sq3_ff    <= sq3_in;
         near3_ff  <= near3_in;

         side_ff   <= side_in;
         t4_ff     <= t3_ff;
      end
   end

   assign side_out    = side_ff;
   assign elapsed_out = t4_ff;

endmodule

>>> design/ctg_poly.sv
// Blend polynomial stages: from s = t/T to the position, velocity and acceleration factors.
// Depends on ctg_pkg for the coefficient bundle.
module ctg_poly (
   input  logic              clock,
   input  logic              advance,
   input  logic [27:0]       s_in,
   output ctg_pkg::coef_type coef_out
);
   import ctg_pkg::*;

   logic [27:0]        s1_ff, s2a_ff;
   logic [28:0]        pm1_ff;
   logic [31:0]        c3a_ff, c3b_ff;
   logic [27:0]        s2b_ff, s3_ff;
   logic [28:0]        c2b_ff;
   coef_type           coef_ff, coef_in;

   logic [55:0]        sq_v, cube_v;
   logic [56:0]        pm_v;
   logic [31:0]        c3_v;

   always_comb begin
      sq_v   = 56'(s_in) * 56'(s_in);
      pm_v   = 57'(s_in) * 57'(ONE_Q - 29'(s_in));
      c3_v   = C3_BASE - 32'(s_in) * 32'd12;
      cube_v = 56'(s2a_ff) * 56'(s1_ff);
      coef_in.c1    = 30'(30'(s2b_ff) * 30'd3) - 30'(30'(s3_ff) * 30'd2);
      coef_in.c2    = c2b_ff;
      coef_in.c3neg = c3b_ff[31];
      coef_in.c3m   = c3b_ff[31] ? 31'(-c3b_ff) : c3b_ff[30:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff   <= s_in;
         s2a_ff  <= sq_v[55:FRAC];
         pm1_ff  <= pm_v[56:FRAC];
         c3a_ff  <= c3_v;

         s2b_ff  <= s2a_ff;
         s3_ff   <= cube_v[55:FRAC];
         c2b_ff  <= 29'(pm1_ff * 29'd6);
         c3b_ff  <= c3a_ff;

         coef_ff <= coef_in;
      end
   end

   assign coef_out = coef_ff;

endmodule

>>> design/ctg_axis.sv
// One axis: position blend, velocity and acceleration division and scaling, saturation.
// Depends on ctg_pkg and instantiates two ctg_divider pipelines.
module ctg_axis (
   input  logic              clock,
   input  logic              advance,
   input  logic [31:0]       dmag_in,
   input  logic              dneg_in,
   input  logic [31:0]       start_in,
   input  ctg_pkg::coef_type coef_in,
   input  logic [19:0]       duration_in,
   input  logic [39:0]       dur_sq_in,
   input  logic [31:0]       cur_in,
   input  logic              pass_in,
   output logic [31:0]       pos_out,
   output logic [31:0]       vel_out,
   output logic [31:0]       acc_out
);
   import ctg_pkg::*;

   logic [61:0]        prod_pos_ff;
   logic [60:0]        prod_vel_ff;
   logic [62:0]        prod_acc_ff;
   logic               negv_ff, nega_ff;
   logic [31:0]        start_ff;

   logic [31:0]        pos_line_ff [TAIL_DELAY];
   logic               negv_line_ff [TAIL_DELAY];
   logic               nega_line_ff [TAIL_DELAY];

   logic [63:0]        quot_v, quot_a;
   logic [49:0]        qv_ff;
   logic [39:0]        qa_ff;
   logic               bigv_ff, biga_ff, bigv2_ff, biga2_ff;
   logic [59:0]        mv_ff, ma_ff;

   logic [31:0]        pos_ff, vel_ff, acc_ff;
   logic [31:0]        pos_in, vel_in, acc_in;

   logic [33:0]        step_v;
   logic signed [34:0] sum_v;
   logic [30:0]        rv_v, ra_v;

   ctg_divider vel_div (
      .clock    (clock),
      .advance  (advance),
      .dividend ({3'b000, prod_vel_ff}),
      .divisor  ({20'b0, duration_in}),
      .quotient (quot_v)
   );

   ctg_divider acc_div (
      .clock    (clock),
      .advance  (advance),
      .dividend ({1'b0, prod_acc_ff}),
      .divisor  (dur_sq_in),
      .quotient (quot_a)
   );

   always_comb begin
      step_v = prod_pos_ff[61:FRAC];
      if (negv_ff) begin
         sum_v = $signed({{3{start_ff[31]}}, start_ff}) - $signed({1'b0, step_v});
      end else begin
         sum_v = $signed({{3{start_ff[31]}}, start_ff}) + $signed({1'b0, step_v});
      end
      if (sum_v > $signed(35'(SAT_MAX))) begin
         pos_in = SAT_MAX;
      end else if (sum_v < -$signed(35'(SAT_MIN))) begin
         pos_in = SAT_MIN;
      end else begin
         pos_in = sum_v[31:0];
      end
   end

   // The limits keep the scaled magnitudes below 2^31 when not saturating.
   always_comb begin
      rv_v = mv_ff[58:FRAC];
      ra_v = ma_ff[58:FRAC];
      if (bigv2_ff) begin
         vel_in = negv_line_ff[TAIL_DELAY-1] ? SAT_MIN : SAT_MAX;
      end else begin
         vel_in = negv_line_ff[TAIL_DELAY-1] ? 32'(-{1'b0, rv_v}) : {1'b0, rv_v};
      end
      if (biga2_ff) begin
         acc_in = nega_line_ff[TAIL_DELAY-1] ? SAT_MIN : SAT_MAX;
      end else begin
         acc_in = nega_line_ff[TAIL_DELAY-1] ? 32'(-{1'b0, ra_v}) : {1'b0, ra_v};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_pos_ff <= 62'(dmag_in) * 62'(coef_in.c1);
         prod_vel_ff <= 61'(dmag_in) * 61'(coef_in.c2);
         prod_acc_ff <= 63'(dmag_in) * 63'(coef_in.c3m);
         negv_ff     <= dneg_in;
         nega_ff     <= dneg_in ^ coef_in.c3neg;
         start_ff    <= start_in;

         pos_line_ff[0]  <= pos_in;
         negv_line_ff[0] <= negv_ff;
         nega_line_ff[0] <= nega_ff;
         for (int k = 1; k < TAIL_DELAY; k++) begin
            pos_line_ff[k]  <= pos_line_ff[k-1];
            negv_line_ff[k] <= negv_line_ff[k-1];
            nega_line_ff[k] <= nega_line_ff[k-1];
         end

         bigv_ff  <= quot_v >= VEL_LIMIT;
         biga_ff  <= quot_a >= ACC_LIMIT;
         qv_ff    <= quot_v[49:0];
         qa_ff    <= quot_a[39:0];

         bigv2_ff <= bigv_ff;
         biga2_ff <= biga_ff;
         mv_ff    <= 60'(qv_ff) * 60'(MS_PER_S);
         ma_ff    <= 60'(qa_ff) * 60'(MS2_PER_S2);

         pos_ff   <= pass_in ? cur_in : pos_line_ff[TAIL_DELAY-1];
         vel_ff   <= pass_in ? '0 : vel_in;
         acc_ff   <= pass_in ? '0 : acc_in;
      end
   end

   assign pos_out = pos_ff;
   assign vel_out = vel_ff;
   assign acc_out = acc_ff;

endmodule

>>> sim/ctg_checker.sv
// Response checker for the cubic trajectory generator: predicts each response beat.
// Depends on ctg_pkg; watches the request and response channels of the block.
`timescale 1ns / 100ps

module ctg_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [19:0]        req_elapsed_ms,
   input  logic               req_new_move,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_ref_pos_x,
   input  logic signed [31:0] rsp_ref_pos_y,
   input  logic signed [31:0] rsp_ref_pos_z,
   input  logic signed [31:0] rsp_ref_vel_x,
   input  logic signed [31:0] rsp_ref_vel_y,
   input  logic signed [31:0] rsp_ref_vel_z,
   input  logic signed [31:0] rsp_ref_acc_x,
   input  logic signed [31:0] rsp_ref_acc_y,
   input  logic signed [31:0] rsp_ref_acc_z,
   input  logic               rsp_holding,
   input  logic               cfg_we,
   input  ctg_pkg::reg_index_type cfg_index,
   input  logic [31:0]        cfg_value,
   output int                 pending,
   output int                 fail_count,
   output int                 hold_seen,
   output int                 move_seen
);
   import ctg_pkg::*;

   typedef struct {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
      logic [2:0][31:0] acc;
      logic             holding;
   } reference_type;

   reference_type reference_q[$];

   longint target[3];
   longint duration;
   longint tolerance;
   longint start_pos[3];
   bit     arm_latch;

   function automatic logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return SAT_MAX;
      if (v < -64'sd2147483648) return SAT_MIN;
      return v[31:0];
   endfunction

   function automatic longint unsigned magnitude(longint v);
      return v < 0 ? -v : v;
   endfunction

   // Divides, scales to seconds and drops the Q.28 fraction, capped at 2^40.
   function automatic logic [31:0] rate_term(longint unsigned mag, bit neg,
                                             longint unsigned div, longint unsigned mul);
      longint unsigned q, r;
      q = mag / div;
      if (q > 64'hFFFF_FFFF_FFFF_FFFF / mul) r = 64'd1 << 40;
      else r = (q * mul) >> FRAC;
      if (r > (64'd1 << 40)) r = 64'd1 << 40;
      return clamp32(neg ? -longint'(r) : longint'(r));
   endfunction

   function automatic reference_type trajectory_point(longint cur[3], longint t);
      reference_type res;
      bit hold, near;
      longint unsigned m, sum, s, s2, s3, c1, c2, c3m, dm;
      longint c3, d, stepv;
      sum = 0;
      hold = (t >= duration);
      if (!hold && tolerance != 0) begin
         near = 1;
         for (int i = 0; i < 3; i++) begin
            m = magnitude(cur[i] - target[i]);
            if (m >= tolerance) near = 0;
            else if (near) sum += m * m;
         end
         if (near && sum < tolerance * tolerance) hold = 1;
      end
      for (int i = 0; i < 3; i++) begin
         res.pos[i] = clamp32(cur[i]);
         res.vel[i] = '0;
         res.acc[i] = '0;
      end
      res.holding = hold;
      if (hold) return res;
      s = (t << FRAC) / duration;
      s2 = (s * s) >> FRAC;
      s3 = (s2 * s) >> FRAC;
      c1 = 3 * s2 - 2 * s3;
      c2 = 6 * ((s * ((64'd1 << FRAC) - s)) >> FRAC);
      c3 = longint'(6 * (64'd1 << FRAC)) - longint'(12 * s);
      c3m = magnitude(c3);
      for (int i = 0; i < 3; i++) begin
         d = target[i] - start_pos[i];
         dm = magnitude(d);
         stepv = longint'((dm * c1) >> FRAC);
         res.pos[i] = clamp32(start_pos[i] + (d < 0 ? -stepv : stepv));
         res.vel[i] = rate_term(dm * c2, d < 0, duration, 1000);
         res.acc[i] = rate_term(dm * c3m, (d < 0) != (c3 < 0), duration * duration, 1000000);
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   assign pending = reference_q.size();

   always @(posedge clock) begin
      longint cur[3];
      reference_type want;
      logic [2:0][31:0] got_pos, got_vel, got_acc;
      if (reset) begin
         reference_q.delete();
         target[0] = 0; target[1] = 0; target[2] = 65536;
         duration = 5000; tolerance = 655;
         start_pos[0] = 0; start_pos[1] = 0; start_pos[2] = 0;
         arm_latch = 1;
         fail_count = 0; hold_seen = 0; move_seen = 0;
      end else begin
         if (cfg_we) begin
            case (cfg_index)
               REG_TARGET_X:       target[0] = longint'(signed'(cfg_value));
               REG_TARGET_Y:       target[1] = longint'(signed'(cfg_value));
               REG_TARGET_Z:       target[2] = cfg_value[30:0];
               REG_MOVE_DURATION:  duration = cfg_value[19:0];
               REG_STOP_TOLERANCE: tolerance = cfg_value[30:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            cur[0] = req_pos_x; cur[1] = req_pos_y; cur[2] = req_pos_z;
            if (arm_latch || req_new_move) begin
               start_pos = cur;
               arm_latch = 0;
            end
            reference_q.push_back(trajectory_point(cur, req_elapsed_ms));
         end
         if (rsp_valid && rsp_ready) begin
            got_pos = {rsp_ref_pos_z, rsp_ref_pos_y, rsp_ref_pos_x};
            got_vel = {rsp_ref_vel_z, rsp_ref_vel_y, rsp_ref_vel_x};
            got_acc = {rsp_ref_acc_z, rsp_ref_acc_y, rsp_ref_acc_x};
            if (reference_q.size() == 0) begin
               $display("unexpected response beat at %0t", $time);
               fail_count++;
            end else begin
               want = reference_q.pop_front();
               if (want.holding) hold_seen++; else move_seen++;
               for (int i = 0; i < 3; i++) begin
                  if (got_pos[i] !== want.pos[i]) report_mismatch($sformatf("pos[%0d]", i),
                                                                   got_pos[i], want.pos[i]);
                  if (got_vel[i] !== want.vel[i]) report_mismatch($sformatf("vel[%0d]", i),
                                                                   got_vel[i], want.vel[i]);
                  if (got_acc[i] !== want.acc[i]) report_mismatch($sformatf("acc[%0d]", i),
                                                                   got_acc[i], want.acc[i]);
               end
               if (rsp_holding !== want.holding)
                  report_mismatch("holding", rsp_holding, want.holding);
            end
         end
      end
   end
endmodule

>>> sim/tb.sv
// Testbench top for the cubic trajectory generator: clock, reset, stimulus and verdict.
// Depends on ctg_pkg, cubic_trajectory_generator and ctg_checker.
`timescale 1ns / 100ps

module tb;
   import ctg_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic clock, reset;
   logic req_valid, req_ready, req_new_move;
   logic signed [31:0] req_pos_x, req_pos_y, req_pos_z;
   logic [19:0] req_elapsed_ms;
   logic rsp_valid, rsp_ready, rsp_holding;
   logic signed [31:0] rsp_ref_pos_x, rsp_ref_pos_y, rsp_ref_pos_z;
   logic signed [31:0] rsp_ref_vel_x, rsp_ref_vel_y, rsp_ref_vel_z;
   logic signed [31:0] rsp_ref_acc_x, rsp_ref_acc_y, rsp_ref_acc_z;
   logic psel, penable, pwrite, pready;
   logic [4:0] paddr;
   logic [31:0] pwdata, prdata;

   int pending, fail_count, hold_seen, move_seen;
   int idle_cycles;
   bit calm;           // no random idling on either side while set
   int sink_hold;      // cycles the receiver still holds off
   int hold_req;       // bumped by the stimulus to ask for a long hold-off
   int hold_ack;       // last request the receiver has started
   int beats_sent;

   // The checker sees a register write in the same edge the block takes it.
   wire cfg_we = psel && penable && pwrite && pready;
   reg_index_type cfg_index;
   assign cfg_index = reg_index_type'(paddr[4:2]);

   cubic_trajectory_generator uut (.*);

   ctg_checker scoreboard (
      .clock, .reset, .req_valid, .req_ready, .req_pos_x, .req_pos_y, .req_pos_z,
      .req_elapsed_ms, .req_new_move, .rsp_valid, .rsp_ready,
      .rsp_ref_pos_x, .rsp_ref_pos_y, .rsp_ref_pos_z,
      .rsp_ref_vel_x, .rsp_ref_vel_y, .rsp_ref_vel_z,
      .rsp_ref_acc_x, .rsp_ref_acc_y, .rsp_ref_acc_z, .rsp_holding,
      .cfg_we, .cfg_index, .cfg_value(pwdata),
      .pending, .fail_count, .hold_seen, .move_seen);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // The receiver stalls at random unless told to stay calm, and holds off
   // completely for a long stretch when the stimulus asks for it.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
         sink_hold <= 0;
         hold_ack  <= 0;
      end else if (hold_ack != hold_req) begin
         rsp_ready <= 0;
         sink_hold <= 300;
         hold_ack  <= hold_req;
      end else if (sink_hold > 0) begin
         rsp_ready <= 0;
         sink_hold <= sink_hold - 1;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 36);
      end
   end

   // Watchdog: counts cycles with no accepted beat on either channel while responses are pending.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || pending == 0)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog expired with %0d responses outstanding", pending);
         $display("** cubic_trajectory_generator: FAILED **");
         $finish;
      end
   end

   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      @(posedge clock);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
   endtask

   // Stops offering, waits for every response, then lets the pipeline drain.
   task automatic drain;
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (PIPE_LAT + 10) @(posedge clock);
   endtask

   // Offers one request beat, with a random gap first unless calm. Valid stays
   // high after the beat so that the next one can follow with no gap.
   task automatic send_beat(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                            logic [19:0] t, logic nm);
      while (!calm && $urandom_range(99) < 36) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_pos_x <= px; req_pos_y <= py; req_pos_z <= pz;
      req_elapsed_ms <= t; req_new_move <= nm;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   // A move: start point, then time marching up to and past T; about one beat in ten is random.
   task automatic run_move(logic [19:0] dur, int beats);
      logic [31:0] x0, y0, z0;
      int t;
      x0 = $urandom; y0 = $urandom; z0 = $urandom;
      if ($urandom_range(1)) begin
         x0 = x0 >>> 12; y0 = y0 >>> 12; z0 = z0 >>> 12;
      end
      send_beat(x0, y0, z0, 20'd0, 1'b1);
      for (int k = 1; k < beats; k++) begin
         t = (dur * k) / (beats - 2 > 0 ? beats - 2 : 1);
         if (t > 20'hFFFFF) t = 20'hFFFFF;
         if ($urandom_range(9) == 0)
            send_beat($urandom, $urandom, $urandom, 20'($urandom), 1'($urandom_range(1)));
         else
            send_beat(x0 + $urandom_range(4000) - 2000, y0 + $urandom_range(4000) - 2000,
                      z0, 20'(t), 1'b0);
      end
   endtask

   task automatic random_config(bit extreme);
      logic [19:0] dur;
      csr_write(REG_TARGET_X, extreme ? 32'h7FFF_FFFF : $urandom >>> $urandom_range(20));
      csr_write(REG_TARGET_Y, extreme ? 32'h8000_0000 : $urandom);
      csr_write(REG_TARGET_Z, extreme ? 32'h7FFF_FFFF : $urandom_range(32'h7FFF_FFFF, 1));
      dur = extreme ? 20'hFFFFF : 20'($urandom_range(5000, 1));
      csr_write(REG_MOVE_DURATION, dur);
      csr_write(REG_STOP_TOLERANCE, extreme ? 32'h7FFF_FFFF : $urandom_range(70000));
   endtask

   initial begin
      logic [19:0] dur;
      int phase;
      req_valid = 0; req_pos_x = 0; req_pos_y = 0; req_pos_z = 0;
      req_elapsed_ms = 0; req_new_move = 0;
      psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
      calm = 0; beats_sent = 0; hold_req = 0; phase = 0;
      reset = 1;
      repeat (6) @(posedge clock);
      reset <= 0;

      // Directed: the first beat latches the start point even without the flag.
      send_beat(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 20'd1000, 1'b0);
      send_beat(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 20'd2500, 1'b0);
      send_beat(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 20'd0, 1'b1);
      send_beat(32'h0, 32'h0, 32'h0, 20'd4999, 1'b0);
      send_beat(32'h0, 32'h0, 32'h0, 20'd5000, 1'b0);        // time is up
      send_beat(32'h0, 32'h0, 32'h0001_0000, 20'd100, 1'b0); // on the target: holds
      send_beat(32'h100, 32'h100, 32'h0001_0100, 20'd100, 1'b0);
      send_beat(32'h0, 32'h0, 32'h0, 20'hFFFFF, 1'b1);
      drain();
      // Zero duration and zero tolerance, then the extremes.
      csr_write(REG_MOVE_DURATION, 0);
      csr_write(REG_STOP_TOLERANCE, 0);
      send_beat(32'h1234, 32'h5678, 32'h9ABC, 20'd0, 1'b1);
      send_beat(32'h0, 32'h0, 32'h0001_0000, 20'd0, 1'b0);
      drain();
      random_config(1);
      send_beat(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 20'd0, 1'b1);
      for (int k = 1; k < 8; k++)
         send_beat(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 20'(k * 150000), 1'b0);
      drain();
      csr_write(REG_MOVE_DURATION, 1);
      csr_write(REG_STOP_TOLERANCE, 0);
      send_beat(32'h8000_0000, 32'h0, 32'h0, 20'd0, 1'b1);
      drain();

      // Random phases of well-formed moves under changing settings. The first
      // phase always has a long receiver hold-off and the second runs calm.
      while (beats_sent < 1400) begin
         random_config(0);
         calm = (phase == 1) || ($urandom_range(5) == 0);
         dur = 20'($urandom_range(5000, 1));
         csr_write(REG_MOVE_DURATION, dur);
         if (phase == 0 || $urandom_range(7) == 0)
            hold_req <= hold_req + 1;   // receiver holds off while beats keep coming
         repeat ($urandom_range(6, 2)) run_move(dur, $urandom_range(30, 4));
         drain();   // sender pauses until every response is in
         phase++;
      end

      $display("%0d request beats: %0d moving and %0d holding responses checked.",
               beats_sent, move_seen, hold_seen);
      if (fail_count == 0)
         $display("** cubic_trajectory_generator: PASSED **");
      else
         $display("** cubic_trajectory_generator: FAILED **");
      $finish;
   end
endmodule
